### hw/rtl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the priority task queue
// Field widths, operation and status codes, sequencer states and the control
// bundle handed from the sequencer to the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

   localparam int ENTRIES_DEF   = 64;
   localparam int PRIO_BITS_DEF = 4;

   localparam int ACT_W  = 2;
   localparam int PRIO_W = 4;
   localparam int TAG_W  = 16;
   localparam int ID_W   = 64;
   localparam int STAT_W = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_SUBMIT  = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_CANCEL  = 2'd2,
      ACT_IGNORE  = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_FINISH
   } state_type;

   // per-cycle control of the scan unit
   typedef struct packed {
      logic en;        // an entry is presented this cycle
      logic first;     // it is entry zero
      logic dequeue;   // priority search, else identifier match
   } scan_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/ptq_store.sv
// ----------------------------------------------------------------------------
// ptq_store: task table memory
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_store #(
   parameter int DEPTH  = ptq_pkg::ENTRIES_DEF,
   parameter int DATA_W = 85
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]          wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [DATA_W-1:0]          rd_data
);
   import ptq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/ptq_scan.sv
// ----------------------------------------------------------------------------
// ptq_scan: shared compare unit of the table scan
// Compares each presented entry against the running best priority or the
// wanted identifier and keeps the selected entry and its index.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_scan #(
   parameter int ENTRIES     = ptq_pkg::ENTRIES_DEF,
   parameter int SLOT_PRIO_W = ptq_pkg::PRIO_BITS_DEF
) (
   input  wire logic                                          clock,
   input  wire ptq_pkg::scan_ctl_type                         ctl,
   input  wire logic [SLOT_PRIO_W+ptq_pkg::TAG_W+ptq_pkg::ID_W:0] entry,
   input  wire logic [$clog2(ENTRIES)-1:0]                    entry_idx,
   input  wire logic [ptq_pkg::ID_W-1:0]                      want_id,
   output logic                                               hit,
   output logic [SLOT_PRIO_W+ptq_pkg::TAG_W+ptq_pkg::ID_W:0]  best_data,
   output logic [$clog2(ENTRIES)-1:0]                         sel_idx
);
   import ptq_pkg::*;

   localparam int IdxW    = $clog2(ENTRIES);
   localparam int PrioLsb = 1;
   localparam int TagLsb  = PrioLsb + SLOT_PRIO_W;
   localparam int IdLsb   = TagLsb + TAG_W;
   localparam int DataW   = IdLsb + ID_W;

   logic [DataW-1:0] best_data_ff;
   logic [IdxW-1:0]  sel_idx_ff;
   logic             prio_gt;
   logic             id_eq;
   logic             take;

   assign prio_gt = entry[PrioLsb +: SLOT_PRIO_W] > best_data_ff[PrioLsb +: SLOT_PRIO_W];
   assign id_eq   = entry[IdLsb +: ID_W] == want_id;
   assign take    = ctl.en && (ctl.dequeue ? (ctl.first || prio_gt) : id_eq);
   assign hit     = ctl.en && !ctl.dequeue && id_eq;

   // hold the selected entry
   always_ff @(posedge clock) begin
      if (take) begin
         best_data_ff <= entry;
         sel_idx_ff   <= entry_idx;
      end
   end

   assign best_data = best_data_ff;
   assign sel_idx   = sel_idx_ff;

endmodule

`default_nettype wire

### hw/rtl/priority_task_queue.sv
// ----------------------------------------------------------------------------
// priority_task_queue: table of pending tasks served by priority
// Submit appends a task, dequeue removes the first highest-priority entry and
// fills the hole with the last entry, cancel marks the first matching id.
// ----------------------------------------------------------------------------
// Submit, ignored code, dequeue or cancel on an empty table give the
//   result beat in the cycle after the request beat.
// Dequeue and cancel read the table through the single read port, one entry a
//   cycle; dequeue reads every entry, cancel ends the scan early on a match.
// Throughput: one request at a time; no new request during a scan.
// Reset: occupancy 0, id counter 1; table contents are not cleared.
`default_nettype none

module priority_task_queue #(
   parameter int ENTRIES   = ptq_pkg::ENTRIES_DEF,
   parameter int PRIO_BITS = ptq_pkg::PRIO_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ptq_pkg::ACT_W-1:0]    req_action,
   input  wire logic [ptq_pkg::PRIO_W-1:0]   req_prio_in,
   input  wire logic [ptq_pkg::TAG_W-1:0]    req_tag_in,
   input  wire logic [ptq_pkg::ID_W-1:0]     req_lookup_id,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [ptq_pkg::STAT_W-1:0]        rsp_status,
   output logic [ptq_pkg::ID_W-1:0]          rsp_id_out,
   output logic [ptq_pkg::TAG_W-1:0]         rsp_tag_out,
   output logic [ptq_pkg::PRIO_W-1:0]        rsp_prio_out,
   output logic                              rsp_was_cancelled
);
   import ptq_pkg::*;

   localparam int IdxW      = $clog2(ENTRIES);
   localparam int CntW      = $clog2(ENTRIES + 1);
   localparam int SlotPrioW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
   // table entry layout: {id, tag, prio, cancelled}
   localparam int PrioLsb   = 1;
   localparam int TagLsb    = PrioLsb + SlotPrioW;
   localparam int IdLsb     = TagLsb + TAG_W;
   localparam int DataW     = IdLsb + ID_W;

   // sequencer state
   state_type        state_ff,   state_in;
   logic [CntW-1:0]  occ_ff,     occ_in;
   logic [ID_W-1:0]  id_ctr_ff,  id_ctr_in;
   logic             mode_ff,    mode_in;      // 1: dequeue scan, 0: cancel scan
   logic [ID_W-1:0]  want_ff,    want_in;
   logic [CntW-1:0]  rd_idx_ff,  rd_idx_in;    // next entry to read
   status_type       res_stat_ff, res_stat_in;

   // compare stage: entry read last cycle is in the memory output register
   logic             cmp_valid_ff;
   logic [IdxW-1:0]  cmp_idx_ff;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]  rsp_id_ff,     rsp_id_in;
   logic [TAG_W-1:0] rsp_tag_ff,    rsp_tag_in;
   logic [PRIO_W-1:0] rsp_prio_ff,  rsp_prio_in;
   logic             rsp_canc_ff,   rsp_canc_in;

   // table ports
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr;
   logic [DataW-1:0] wr_data;
   logic             rd_en;
   logic [DataW-1:0] rd_data;

   // scan unit
   scan_ctl_type     scan_ctl;
   logic             scan_hit;
   logic [DataW-1:0] best_data;
   logic [IdxW-1:0]  sel_idx;

   logic             out_free;
   logic             scan_last;
   logic             table_full;
   logic             table_empty;

   ptq_store #(
      .DEPTH  (ENTRIES),
      .DATA_W (DataW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IdxW-1:0]),
      .rd_data (rd_data)
   );

   assign scan_ctl.en      = (state_ff == S_SCAN) && cmp_valid_ff;
   assign scan_ctl.first   = (cmp_idx_ff == '0);
   assign scan_ctl.dequeue = mode_ff;

   ptq_scan #(
      .ENTRIES     (ENTRIES),
      .SLOT_PRIO_W (SlotPrioW)
   ) u_scan (
      .clock     (clock),
      .ctl       (scan_ctl),
      .entry     (rd_data),
      .entry_idx (cmp_idx_ff),
      .want_id   (want_ff),
      .hit       (scan_hit),
      .best_data (best_data),
      .sel_idx   (sel_idx)
   );

   // the response register can take a new beat this cycle
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign scan_last   = CntW'(cmp_idx_ff) == (occ_ff - CntW'(1));
   assign table_full  = occ_ff == CntW'(ENTRIES);
   assign table_empty = occ_ff == '0;

   // Issue one table read per cycle while entries remain in the scan.
   assign rd_en = (state_ff == S_SCAN) && (rd_idx_ff < occ_ff);

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      id_ctr_in     = id_ctr_ff;
      mode_in       = mode_ff;
      want_in       = want_ff;
      rd_idx_in     = rd_idx_ff;
      res_stat_in   = res_stat_ff;
      wr_en         = 1'b0;
      wr_addr       = occ_ff[IdxW-1:0];
      wr_data       = {id_ctr_ff, req_tag_in, req_prio_in[SlotPrioW-1:0], 1'b0};
      req_stall     = 1'b1;
      // response register: drop the beat once taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_canc_in   = rsp_canc_ff;

      case (state_ff)
         S_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               rd_idx_in = '0;
               case (action_type'(req_action))
                  ACT_SUBMIT: begin
                     rsp_valid_in = 1'b1;
                     rsp_tag_in   = '0;
                     rsp_prio_in  = '0;
                     rsp_canc_in  = 1'b0;
                     if (table_full) begin
                        rsp_status_in = STAT_FULL;
                        rsp_id_in     = '0;
                     end else begin
                        // append at the end of the table
                        wr_en         = 1'b1;
                        occ_in        = occ_ff + CntW'(1);
                        id_ctr_in     = id_ctr_ff + ID_W'(1);
                        rsp_status_in = STAT_OK;
                        rsp_id_in     = id_ctr_ff;
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (table_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_id_in     = '0;
                        rsp_tag_in    = '0;
                        rsp_prio_in   = '0;
                        rsp_canc_in   = 1'b0;
                     end else begin
                        mode_in  = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_CANCEL: begin
                     if (table_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NOT_FOUND;
                        rsp_id_in     = '0;
                        rsp_tag_in    = '0;
                        rsp_prio_in   = '0;
                        rsp_canc_in   = 1'b0;
                     end else begin
                        mode_in  = 1'b0;
                        want_in  = req_lookup_id;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     // unused code: answer ok, leave the table alone
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_id_in     = '0;
                     rsp_tag_in    = '0;
                     rsp_prio_in   = '0;
                     rsp_canc_in   = 1'b0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CntW'(1);
            end
            if (scan_ctl.en) begin
               if (scan_hit) begin
                  state_in = S_COMMIT;
               end else if (scan_last) begin
                  if (mode_ff) begin
                     state_in = S_COMMIT;
                  end else begin
                     res_stat_in = STAT_NOT_FOUND;
                     state_in    = S_FINISH;
                  end
               end
            end
         end
         S_COMMIT: begin
            wr_en       = 1'b1;
            wr_addr     = sel_idx;
            res_stat_in = STAT_OK;
            state_in    = S_FINISH;
            if (mode_ff) begin
               // last entry (still in the read register) fills the hole
               wr_data = rd_data;
               occ_in  = occ_ff - CntW'(1);
            end else begin
               wr_data = {best_data[DataW-1:1], 1'b1};
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_stat_ff;
               rsp_id_in     = '0;
               rsp_tag_in    = '0;
               rsp_prio_in   = '0;
               rsp_canc_in   = 1'b0;
               if (res_stat_ff == STAT_OK) begin
                  if (mode_ff) begin
                     rsp_id_in   = best_data[IdLsb +: ID_W];
                     rsp_tag_in  = best_data[TagLsb +: TAG_W];
                     rsp_prio_in = PRIO_W'(best_data[PrioLsb +: SlotPrioW]);
                     rsp_canc_in = best_data[0];
                  end else begin
                     rsp_id_in = want_ff;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         id_ctr_ff    <= ID_W'(1);
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         id_ctr_ff    <= id_ctr_in;
         cmp_valid_ff <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      want_ff       <= want_in;
      rd_idx_ff     <= rd_idx_in;
      res_stat_ff   <= res_stat_in;
      cmp_idx_ff    <= rd_idx_ff[IdxW-1:0];
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_canc_ff   <= rsp_canc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_id_out        = rsp_id_ff;
   assign rsp_tag_out       = rsp_tag_ff;
   assign rsp_prio_out      = rsp_prio_ff;
   assign rsp_was_cancelled = rsp_canc_ff;

endmodule

`default_nettype wire
